// ----- rtl/status_led_flash_mux_core_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef STATUS_LED_FLASH_MUX_CORE_MACROS_SVH
`define STATUS_LED_FLASH_MUX_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLFM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLFM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/slfm_pkg.sv -----
`default_nettype none
package slfm_pkg;

  // Event codes
  typedef enum logic [1:0] {
    CMD_PROFILE    = 2'd0,
    CMD_CONNECT    = 2'd1,
    CMD_DISCONNECT = 2'd2,
    CMD_TICK       = 2'd3
  } cmd_e;

  // Configuration register indexes
  localparam logic [1:0] REG_FLASH_TICKS    = 2'd0;
  localparam logic [1:0] REG_DWELL_TICKS    = 2'd1;
  localparam logic [1:0] REG_PROFILE_COLORS = 2'd2;

  // Reset values of the configuration registers
  localparam logic [15:0] FLASH_TICKS_RST    = 16'd1000;
  localparam logic [7:0]  DWELL_TICKS_RST    = 8'd4;
  localparam logic [14:0] PROFILE_COLORS_RST = 15'd26452;

  // Colour bits
  localparam logic [2:0] COL_RED = 3'b001;
  localparam logic [2:0] COL_YG  = 3'b010;
  localparam logic [2:0] COL_GRN = 3'b100;

  typedef struct packed {
    logic [15:0] flash_ticks;
    logic [7:0]  dwell_ticks;
    logic [14:0] profile_colors;
  } cfg_t;

  typedef struct packed {
    cmd_e       command;
    logic [2:0] profile_index;
    logic       from_split_link;
    logic       connect_failed;
  } evt_t;

  // Colour mask of one profile; profiles beyond the register have none
  function automatic logic [2:0] profile_mask(input logic [14:0] colors,
                                              input logic [2:0] idx);
    logic [2:0] m;
    unique case (idx)
      3'd0:    m = colors[2:0];
      3'd1:    m = colors[5:3];
      3'd2:    m = colors[8:6];
      3'd3:    m = colors[11:9];
      3'd4:    m = colors[14:12];
      default: m = 3'b000;
    endcase
    return m;
  endfunction

  // Two or more colours wanted
  function automatic logic multi_color(input logic [2:0] m);
    return (m[0] & m[1]) | (m[0] & m[2]) | (m[1] & m[2]);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/slfm_cfg.sv -----
`default_nettype none
module slfm_cfg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_en_i,
  input  wire logic [1:0]     wr_index_i,
  input  wire logic [15:0]    wr_data_i,
  output slfm_pkg::cfg_t      cfg_o
);
  import slfm_pkg::*;

  logic [15:0] flash_ticks_q;
  logic [7:0]  dwell_ticks_q;
  logic [14:0] profile_colors_q;

  // Register file; writes to an unused index are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_ticks_q    <= FLASH_TICKS_RST;
      dwell_ticks_q    <= DWELL_TICKS_RST;
      profile_colors_q <= PROFILE_COLORS_RST;
    end else if (wr_en_i) begin
      if (wr_index_i == REG_FLASH_TICKS)    flash_ticks_q    <= wr_data_i;
      if (wr_index_i == REG_DWELL_TICKS)    dwell_ticks_q    <= wr_data_i[7:0];
      if (wr_index_i == REG_PROFILE_COLORS) profile_colors_q <= wr_data_i[14:0];
    end
  end

  assign cfg_o.flash_ticks    = flash_ticks_q;
  assign cfg_o.dwell_ticks    = dwell_ticks_q;
  assign cfg_o.profile_colors = profile_colors_q;

endmodule
`default_nettype wire

// ----- rtl/slfm_engine.sv -----
`default_nettype none
`include "status_led_flash_mux_core_macros.svh"
module slfm_engine #(
  parameter int NUM_PROFILES = 5,
  parameter int NUM_CHANNELS = 3
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           evt_en_i,
  input  slfm_pkg::evt_t      evt_i,
  input  slfm_pkg::cfg_t      cfg_i,
  output logic [2:0]          drive_o
);
  import slfm_pkg::*;

  localparam int PosW = $clog2(NUM_CHANNELS);
  localparam logic [3:0] NumProf = 4'(NUM_PROFILES);
  localparam logic [PosW:0] NumCh = (PosW + 1)'(NUM_CHANNELS);

  logic            link_lost_q, link_lost_d;
  logic            flash_active_q, flash_active_d;
  logic [2:0]      flash_colors_q, flash_colors_d;
  logic [15:0]     flash_cnt_q, flash_cnt_d;
  logic            mux_active_q, mux_active_d;
  logic [PosW-1:0] mux_pos_q, mux_pos_d;
  logic [7:0]      dwell_cnt_q, dwell_cnt_d;
  logic [2:0]      drive_q, drive_d;

  logic            do_apply;
  logic [2:0]      m_apply;
  logic [2:0]      prof_mask;
  logic            prof_ok;
  logic [2:0]      wanted_now;

  assign prof_mask  = profile_mask(cfg_i.profile_colors, evt_i.profile_index);
  assign prof_ok    = {1'b0, evt_i.profile_index} < NumProf;
  assign wanted_now = (flash_active_q ? flash_colors_q : 3'b000) |
                      (link_lost_q ? COL_RED : 3'b000);

  // Event decode and state update
  always_comb begin
    logic [PosW:0]   sum;
    logic [PosW:0]   cand;
    logic [3:0]      cand4;
    logic [PosW-1:0] step_pos;
    logic [2:0]      step_drive;
    sum            = '0;
    cand           = '0;
    cand4          = 4'd0;
    step_pos       = mux_pos_q;
    step_drive     = 3'b000;
    link_lost_d    = link_lost_q;
    flash_active_d = flash_active_q;
    flash_colors_d = flash_colors_q;
    flash_cnt_d    = flash_cnt_q;
    mux_active_d   = mux_active_q;
    mux_pos_d      = mux_pos_q;
    dwell_cnt_d    = dwell_cnt_q;
    drive_d        = drive_q;
    do_apply       = 1'b0;
    m_apply        = wanted_now;
    if (evt_en_i) begin
      unique case (evt_i.command)
        CMD_PROFILE: begin
          if (prof_ok) begin
            flash_colors_d = prof_mask;
            flash_active_d = 1'b1;
            flash_cnt_d    = cfg_i.flash_ticks;
            do_apply       = 1'b1;
            m_apply        = prof_mask | (link_lost_q ? COL_RED : 3'b000);
          end
        end
        CMD_CONNECT: begin
          if (!evt_i.connect_failed && evt_i.from_split_link) begin
            link_lost_d = 1'b0;
            do_apply    = 1'b1;
            m_apply     = flash_active_q ? flash_colors_q : 3'b000;
          end
        end
        CMD_DISCONNECT: begin
          if (evt_i.from_split_link) begin
            link_lost_d = 1'b1;
            do_apply    = 1'b1;
            m_apply     = wanted_now | COL_RED;
          end
        end
        CMD_TICK: begin
          if (flash_active_q && flash_cnt_q <= 16'd1) begin
            // flash expiry: re-apply, no second mux step this tick
            flash_cnt_d    = 16'd0;
            flash_active_d = 1'b0;
            flash_colors_d = 3'b000;
            do_apply       = 1'b1;
            m_apply        = link_lost_q ? COL_RED : 3'b000;
          end else begin
            if (flash_active_q) flash_cnt_d = flash_cnt_q - 16'd1;
            if (mux_active_q) begin
              if (dwell_cnt_q <= 8'd1) begin
                dwell_cnt_d = 8'd0;
                do_apply    = 1'b1;
                m_apply     = wanted_now;
              end else begin
                dwell_cnt_d = dwell_cnt_q - 8'd1;
              end
            end
          end
        end
      endcase
    end
    // Apply: multiplex two or more colours, else drive statically
    if (do_apply) begin
      if (multi_color(m_apply)) begin
        // Round-robin search: next wanted channel after the current position
        for (int k = NUM_CHANNELS; k >= 1; k--) begin
          sum   = {1'b0, mux_pos_q} + (PosW + 1)'(k);
          cand  = (sum >= NumCh) ? sum - NumCh : sum;
          cand4 = 4'(cand);
          if (cand4 < 4'd3 && m_apply[cand4[1:0]]) begin
            step_pos   = cand[PosW-1:0];
            step_drive = 3'b001 << cand4[1:0];
          end
        end
        mux_active_d = 1'b1;
        mux_pos_d    = step_pos;
        drive_d      = step_drive;
        dwell_cnt_d  = cfg_i.dwell_ticks;
      end else begin
        mux_active_d = 1'b0;
        drive_d      = m_apply;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_lost_q    <= 1'b1;
      flash_active_q <= 1'b0;
      flash_colors_q <= 3'b000;
      flash_cnt_q    <= 16'd0;
      mux_active_q   <= 1'b0;
      mux_pos_q      <= '0;
      dwell_cnt_q    <= 8'd0;
      drive_q        <= COL_RED;
    end else begin
      link_lost_q    <= link_lost_d;
      flash_active_q <= flash_active_d;
      flash_colors_q <= flash_colors_d;
      flash_cnt_q    <= flash_cnt_d;
      mux_active_q   <= mux_active_d;
      mux_pos_q      <= mux_pos_d;
      dwell_cnt_q    <= dwell_cnt_d;
      drive_q        <= drive_d;
    end
  end

  assign drive_o = drive_q;

  // Checks
  `SLFM_ASSERT_IMP(a_mux_onehot, clk_i, rst_ni, mux_active_q, $onehot(drive_q),
                   "multiplexed drive is not one-hot")
  `SLFM_ASSERT_IMP(a_static_single, clk_i, rst_ni, !mux_active_q,
                   $countones(drive_q) <= 1, "static drive has several colours")
  `SLFM_ASSERT_IMP(a_flash_cleared, clk_i, rst_ni, !flash_active_q,
                   flash_colors_q == 3'b000, "stale flash colours")
  `SLFM_ASSERT_IMP(a_drive_wanted, clk_i, rst_ni, 1'b1,
                   (drive_q & ~wanted_now) == 3'b000, "lit colour not wanted")

endmodule
`default_nettype wire

// ----- rtl/status_led_flash_mux_core.sv -----
// Ch  | Handshake               | Fields
// ----+-------------------------+------------------------------------------------------------
// cfg | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// in  | in_valid_i/in_ready_o   | command_i, profile_index_i, from_split_link_i, connect_failed_i
// out | out_valid_o/out_ready_i | led_drive_o
//
// One word in, one word out; a word is accepted every cycle that in_ready_o is high,
// its result is valid in the next cycle (state update and mux search are combinational).
// The drive register doubles as the output register; in_ready_o drops only
// while a result waits and out_ready_i is low.
// cfg_ready_o is always high. Reset: red lit, link lost, no result pending.
`default_nettype none
`include "status_led_flash_mux_core_macros.svh"
module status_led_flash_mux_core #(
  parameter int NUM_PROFILES = 5,
  parameter int NUM_CHANNELS = 3
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [2:0]  profile_index_i,
  input  wire logic        from_split_link_i,
  input  wire logic        connect_failed_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       led_drive_o
);
  import slfm_pkg::*;

  cfg_t cfg;
  evt_t evt;
  logic in_acc;
  logic out_valid_q, out_valid_d;

  assign cfg_ready_o = 1'b1;

  slfm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Input word
  assign evt.command         = cmd_e'(command_i);
  assign evt.profile_index   = profile_index_i;
  assign evt.from_split_link = from_split_link_i;
  assign evt.connect_failed  = connect_failed_i;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  slfm_engine #(
    .NUM_PROFILES (NUM_PROFILES),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .evt_en_i (in_acc),
    .evt_i    (evt),
    .cfg_i    (cfg),
    .drive_o  (led_drive_o)
  );

  // Result pending flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks
  `SLFM_ASSERT_NXT(a_acc_gives_result, clk_i, rst_ni, in_acc, out_valid_q,
                   "accepted word produced no result")
  `SLFM_ASSERT_NXT(a_drive_held, clk_i, rst_ni, !in_acc, $stable(led_drive_o),
                   "drive changed without an accepted word")

endmodule
`default_nettype wire
